// ----- rtl/aiq_pkg.sv -----
`timescale 1ns / 1ps

package aiq_pkg;

  // numerator: signed, at most 2^51 in magnitude
  localparam int NumW  = 53;
  // divisor: signed determinant, exact
  localparam int DenW  = 65;
  // magnitudes
  localparam int NumMagW = NumW - 1;
  localparam int DenMagW = DenW - 1;
  // one quotient bit per step
  localparam int Steps = NumMagW;
  localparam int CntW  = $clog2(Steps);
  localparam int Lanes = 4;
  localparam int FracW = 10;

  // 1.0 squared in Q10
  localparam logic signed [NumW-1:0] OneSq = NumW'(1) <<< (2 * FracW);
  localparam logic signed [NumW-1:0] NumZero = '0;
  localparam logic signed [DenW-1:0] DenOne  = DenW'(1);

  typedef struct packed {
    logic signed [NumW-1:0] num;
    logic signed [DenW-1:0] den;
  } lane_t;

  typedef struct packed {
    lane_t [Lanes-1:0]  lane;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic               fail;
  } job_t;

endpackage

// ----- rtl/affine_inverse_q10.sv -----
`timescale 1ns / 1ps

// inverse of a 2x3 affine matrix in Q10 fixed point, with a singular flag
// input: drive in_* and raise start; the item is taken on a clock edge with
//   start high and busy low
// output: out_valid is high for exactly one cycle with the inverse on out_*;
//   the receiver cannot stall, so results are never held back
// a singular matrix gives all six matrix outputs zero and out_singular high
// an item passes the front registers, the queue and the back end; a singular
//   one skips the dividers and the translation products
// the back end takes one item at a time, held by the four lockstep
//   restoring dividers that make one quotient bit per cycle over 52 bits
// the front stage classifies and builds the determinant while the back end
//   divides; a two-entry queue between them lets the front take four
//   more items before busy rises
// reset (synchronous, active low) empties the pipeline and the queue

module affine_inverse_q10 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_xx,
  input  logic signed [31:0] in_yx,
  input  logic signed [31:0] in_xy,
  input  logic signed [31:0] in_yy,
  input  logic signed [31:0] in_tx,
  input  logic signed [31:0] in_ty,
  output logic               out_valid,
  output logic signed [31:0] out_xx,
  output logic signed [31:0] out_yx,
  output logic signed [31:0] out_xy,
  output logic signed [31:0] out_yy,
  output logic signed [31:0] out_tx,
  output logic signed [31:0] out_ty,
  output logic               out_singular
);

  // queue handshake between front and back
  logic          q_full, q_push, q_empty, q_pop;
  aiq_pkg::job_t q_in, q_head;

  // front: products, classification, determinant, divider operands
  aiq_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .in_xx (in_xx),
    .in_yx (in_yx),
    .in_xy (in_xy),
    .in_yy (in_yy),
    .in_tx (in_tx),
    .in_ty (in_ty),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_in)
  );

  // decouples the classify stages from the long divide
  aiq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back: four divides, then translation products and output register
  aiq_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_xx      (out_xx),
    .out_yx      (out_yx),
    .out_xy      (out_xy),
    .out_yy      (out_yy),
    .out_tx      (out_tx),
    .out_ty      (out_ty),
    .out_singular(out_singular)
  );

endmodule

// ----- rtl/aiq_front.sv -----
`timescale 1ns / 1ps

module aiq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_xx,
  input  logic signed [31:0] in_yx,
  input  logic signed [31:0] in_xy,
  input  logic signed [31:0] in_yy,
  input  logic signed [31:0] in_tx,
  input  logic signed [31:0] in_ty,
  input  logic               q_full,
  output logic               q_push,
  output aiq_pkg::job_t      q_data
);

  typedef enum logic [1:0] {PathScale, PathSwap, PathGen} path_t;

  logic               s1_v_r;
  logic signed [31:0] xx_r, yx_r, xy_r, yy_r, tx_r, ty_r;
  logic signed [63:0] p_diag_r, p_anti_r;
  path_t              path_r;
  logic               s2_v_r;
  aiq_pkg::job_t      job_r;

  logic               s1_ready, s2_ready, s1_move, accept;
  logic signed [63:0] p_diag, p_anti;
  path_t              path_nxt;
  logic signed [aiq_pkg::DenW-1:0] det;
  aiq_pkg::job_t      job_nxt;

  assign s2_ready = !s2_v_r || !q_full;
  assign s1_ready = !s1_v_r || s2_ready;
  assign s1_move  = s1_v_r && s2_ready;
  assign busy     = !s1_ready;
  assign accept   = start && !busy;
  assign q_push   = s2_v_r && !q_full;
  assign q_data   = job_r;

  assign p_diag = in_xx * in_yy;
  assign p_anti = in_yx * in_xy;

  // classify on the raw coefficients
  always_comb begin
    if (in_yx == '0 && in_xy == '0) begin
      path_nxt = PathScale;
    end else if (in_xx == '0 && in_yy == '0) begin
      path_nxt = PathSwap;
    end else begin
      path_nxt = PathGen;
    end
  end

  assign det = {p_diag_r[63], p_diag_r} - {p_anti_r[63], p_anti_r};

  always_comb begin
    job_nxt = '0;
    job_nxt.tx = tx_r;
    job_nxt.ty = ty_r;
    for (int i = 0; i < aiq_pkg::Lanes; i++) begin
      job_nxt.lane[i].num = aiq_pkg::NumZero;
      job_nxt.lane[i].den = aiq_pkg::DenOne;
    end
    case (path_r)
      PathScale: begin
        job_nxt.fail        = (xx_r == '0) || (yy_r == '0);
        job_nxt.lane[0].num = aiq_pkg::OneSq;
        job_nxt.lane[0].den = aiq_pkg::DenW'(xx_r);
        job_nxt.lane[3].num = aiq_pkg::OneSq;
        job_nxt.lane[3].den = aiq_pkg::DenW'(yy_r);
      end
      PathSwap: begin
        job_nxt.fail        = (yx_r == '0) || (xy_r == '0);
        job_nxt.lane[1].num = aiq_pkg::OneSq;
        job_nxt.lane[1].den = aiq_pkg::DenW'(xy_r);
        job_nxt.lane[2].num = aiq_pkg::OneSq;
        job_nxt.lane[2].den = aiq_pkg::DenW'(yx_r);
      end
      default: begin
        job_nxt.fail        = (det == '0);
        job_nxt.lane[0].num = $signed({yy_r[31], yy_r, 20'b0});
        job_nxt.lane[1].num = -$signed({yx_r[31], yx_r, 20'b0});
        job_nxt.lane[2].num = -$signed({xy_r[31], xy_r, 20'b0});
        job_nxt.lane[3].num = $signed({xx_r[31], xx_r, 20'b0});
        for (int i = 0; i < aiq_pkg::Lanes; i++) begin
          job_nxt.lane[i].den = det;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        s2_v_r <= 1'b1;
      end else if (q_push) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xx_r     <= in_xx;
      yx_r     <= in_yx;
      xy_r     <= in_xy;
      yy_r     <= in_yy;
      tx_r     <= in_tx;
      ty_r     <= in_ty;
      p_diag_r <= p_diag;
      p_anti_r <= p_anti;
      path_r   <= path_nxt;
    end
    if (s1_move) begin
      job_r <= job_nxt;
    end
  end

endmodule

// ----- rtl/aiq_queue.sv -----
`timescale 1ns / 1ps

module aiq_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  aiq_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output aiq_pkg::job_t head
);

  aiq_pkg::job_t slot_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/aiq_div_lane.sv -----
`timescale 1ns / 1ps

module aiq_div_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  aiq_pkg::lane_t      op,
  output logic                done,
  output logic signed [31:0]  quo
);

  typedef enum logic [1:0] {LIdle, LStep, LFix} lstate_t;

  lstate_t                       state_r;
  logic [aiq_pkg::CntW-1:0]      cnt_r;
  logic [aiq_pkg::NumMagW-1:0]   num_r;
  logic [aiq_pkg::DenMagW-1:0]   den_r;
  logic [aiq_pkg::DenMagW-1:0]   rem_r;
  logic                          neg_r;
  logic                          done_r;
  logic signed [31:0]            quo_r;

  logic [aiq_pkg::NumW-1:0]      num_abs;
  logic [aiq_pkg::DenW-1:0]      den_abs;
  logic [aiq_pkg::DenMagW:0]     shifted;
  logic                          ge;

  assign num_abs = op.num[aiq_pkg::NumW-1] ? -op.num : op.num;
  assign den_abs = op.den[aiq_pkg::DenW-1] ? -op.den : op.den;
  assign shifted = {rem_r, num_r[aiq_pkg::NumMagW-1]};
  assign ge      = (shifted >= {1'b0, den_r});
  assign done    = done_r;
  assign quo     = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LIdle;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        LIdle: begin
          if (go) begin
            state_r <= LStep;
          end
        end
        LStep: begin
          if (cnt_r == '0) begin
            state_r <= LFix;
          end
        end
        LFix: begin
          done_r  <= 1'b1;
          state_r <= LIdle;
        end
        default: state_r <= LIdle;
      endcase
    end
  end

  // restoring divide, one quotient bit per cycle shifted into num_r
  always_ff @(posedge clk) begin
    case (state_r)
      LIdle: begin
        if (go) begin
          num_r <= num_abs[aiq_pkg::NumMagW-1:0];
          den_r <= den_abs[aiq_pkg::DenMagW-1:0];
          neg_r <= op.num[aiq_pkg::NumW-1] ^ op.den[aiq_pkg::DenW-1];
          rem_r <= '0;
          cnt_r <= aiq_pkg::CntW'(aiq_pkg::Steps - 1);
        end
      end
      LStep: begin
        rem_r <= ge ? (shifted[aiq_pkg::DenMagW-1:0] - den_r) : shifted[aiq_pkg::DenMagW-1:0];
        num_r <= {num_r[aiq_pkg::NumMagW-2:0], ge};
        cnt_r <= cnt_r - aiq_pkg::CntW'(1);
      end
      LFix: begin
        quo_r <= neg_r ? -$signed(num_r[31:0]) : $signed(num_r[31:0]);
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/aiq_back.sv -----
`timescale 1ns / 1ps

module aiq_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  aiq_pkg::job_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  output logic signed [31:0] out_xx,
  output logic signed [31:0] out_yx,
  output logic signed [31:0] out_xy,
  output logic signed [31:0] out_yy,
  output logic signed [31:0] out_tx,
  output logic signed [31:0] out_ty,
  output logic               out_singular
);

  typedef enum logic [2:0] {BIdle, BDiv, BM0, BM1, BM2, BM3} bstate_t;

  bstate_t            state_r;
  logic signed [31:0] tx_r, ty_r;
  logic signed [31:0] c_r [aiq_pkg::Lanes];
  logic signed [63:0] pa_r, pb_r;
  logic signed [64:0] sx_r, sy_r;
  logic signed [31:0] otx_r;
  logic               valid_r;
  logic signed [31:0] oxx_r, oyx_r, oxy_r, oyy_r, oty_r;
  logic               sing_r;

  logic [aiq_pkg::Lanes-1:0] lane_done;
  logic signed [31:0]        lane_q [aiq_pkg::Lanes];
  logic                      lane_go;
  logic signed [64:0]        psum;

  // -(s)/1024 truncated toward zero, low 32 bits
  function automatic logic signed [31:0] neg_div(input logic signed [64:0] s);
    logic [41:0] m;
    m = -s[41:0];
    if (s[64]) begin
      return $signed(m[41:10]);
    end
    return -$signed(s[41:10]);
  endfunction

  assign q_pop   = (state_r == BIdle) && !q_empty;
  assign lane_go = q_pop && !q_head.fail;
  assign psum    = {pa_r[63], pa_r} + {pb_r[63], pb_r};

  for (genvar i = 0; i < aiq_pkg::Lanes; i++) begin : g_lane
    aiq_div_lane u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .go   (lane_go),
      .op   (q_head.lane[i]),
      .done (lane_done[i]),
      .quo  (lane_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BIdle;
      valid_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      case (state_r)
        BIdle: begin
          if (q_pop) begin
            if (q_head.fail) begin
              valid_r <= 1'b1;
              oxx_r   <= '0;
              oyx_r   <= '0;
              oxy_r   <= '0;
              oyy_r   <= '0;
              otx_r   <= '0;
              oty_r   <= '0;
              sing_r  <= 1'b1;
            end else begin
              state_r <= BDiv;
            end
            tx_r <= q_head.tx;
            ty_r <= q_head.ty;
          end
        end
        BDiv: begin
          if (&lane_done) begin
            for (int i = 0; i < aiq_pkg::Lanes; i++) begin
              c_r[i] <= lane_q[i];
            end
            state_r <= BM0;
          end
        end
        BM0: begin
          pa_r    <= tx_r * c_r[0];
          pb_r    <= ty_r * c_r[2];
          state_r <= BM1;
        end
        BM1: begin
          pa_r    <= tx_r * c_r[1];
          pb_r    <= ty_r * c_r[3];
          sx_r    <= psum;
          state_r <= BM2;
        end
        BM2: begin
          sy_r    <= psum;
          otx_r   <= neg_div(sx_r);
          state_r <= BM3;
        end
        BM3: begin
          valid_r <= 1'b1;
          oxx_r   <= c_r[0];
          oyx_r   <= c_r[1];
          oxy_r   <= c_r[2];
          oyy_r   <= c_r[3];
          oty_r   <= neg_div(sy_r);
          sing_r  <= 1'b0;
          state_r <= BIdle;
        end
        default: state_r <= BIdle;
      endcase
    end
  end

  assign out_valid    = valid_r;
  assign out_xx       = oxx_r;
  assign out_yx       = oyx_r;
  assign out_xy       = oxy_r;
  assign out_yy       = oyy_r;
  assign out_tx       = otx_r;
  assign out_ty       = oty_r;
  assign out_singular = sing_r;

endmodule
